[hw/rtl/ncs_pkg.sv]
// Shared types, register indexes and a square lookup helper for the
// Nihilist cipher stream block. No dependencies.
package ncs_pkg;

    localparam int CELLS       = 25;
    localparam int KEY_SLOTS   = 12;
    localparam int LETTER_W    = 5;
    localparam int CODE_W      = 6;
    localparam int CFG_DATA_W  = 60;
    localparam int KEY_LEN_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [4:0] LETTER_I      = 5'd8;
    localparam logic [4:0] LETTER_J      = 5'd9;

    // Square code 10*row+column for each cell, row-major.
    localparam logic [CODE_W-1:0] CELL_CODE [CELLS] = '{
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd31, 6'd32, 6'd33, 6'd34, 6'd35,
        6'd41, 6'd42, 6'd43, 6'd44, 6'd45,
        6'd51, 6'd52, 6'd53, 6'd54, 6'd55
    };

    typedef enum logic [2:0] {
        CFG_MODE          = 3'd0,
        CFG_SQUARE_PART_A = 3'd1,
        CFG_SQUARE_PART_B = 3'd2,
        CFG_SQUARE_LAST   = 3'd3,
        CFG_KEY_LETTERS   = 3'd4,
        CFG_KEY_LENGTH    = 3'd5
    } cfg_index_t;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    typedef logic [CELLS-1:0][LETTER_W-1:0]     square_t;
    typedef logic [KEY_SLOTS-1:0][LETTER_W-1:0] key_t;

    typedef struct packed {
        logic [7:0] in_value;
        logic       first_of_message;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_code;
        logic [7:0] out_letter;
        logic       bad_input;
    } out_item_t;

    // Work handed from the front to the back.
    typedef struct packed {
        logic              mode;
        logic [7:0]        value;
        logic [CODE_W-1:0] key_code;
        logic [CODE_W-1:0] letter_code;
    } work_t;

    // Code of the lowest cell holding letter v, zero when none does.
    function automatic logic [CODE_W-1:0] code_of(square_t sq, logic [LETTER_W-1:0] v);
        logic [CODE_W-1:0] c;
        c = '0;
        for (int k = CELLS - 1; k >= 0; k--) begin
            if (sq[k] == v)
            begin
                c = CELL_CODE[k];
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/ncs_front.sv]
// Front end: accepts input beats, tracks the key position and looks up
// the letter and key codes. Depends on ncs_pkg.
module ncs_front #(
    parameter int KEY_MAX = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ncs_pkg::in_item_t in_item,
    input  logic              mode,
    input  ncs_pkg::square_t  square,
    input  ncs_pkg::key_t     key_letters,
    input  logic [3:0]        key_length,
    input  logic              q_full,
    output logic              q_push,
    output ncs_pkg::work_t    q_entry
);
    import ncs_pkg::*;

    localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam logic [4:0] KEY_MAX_W = 5'(KEY_MAX);

    logic [POS_W-1:0]    key_pos_reg;
    logic [POS_W-1:0]    key_pos_next;
    logic [POS_W-1:0]    pos_base;
    logic [POS_W-1:0]    pos_eff;
    logic [4:0]          eff_len;
    logic [4:0]          pos_inc;
    logic [LETTER_W-1:0] key_letter;
    logic [CODE_W-1:0]   key_code;
    logic [7:0]          folded;
    logic                is_letter;
    logic [LETTER_W-1:0] letter_idx;
    logic [CODE_W-1:0]   letter_code;
    logic                drop;
    logic                accept;

    always_comb
    begin
        if (key_length == '0)
        begin
            eff_len = 5'd1;
        end
        else if (5'(key_length) > KEY_MAX_W)
        begin
            eff_len = KEY_MAX_W;
        end
        else
        begin
            eff_len = 5'(key_length);
        end

        pos_base = in_item.first_of_message ? '0 : key_pos_reg;
        pos_eff  = (5'(pos_base) >= eff_len) ? '0 : pos_base;
        pos_inc  = 5'(pos_eff) + 5'd1;

        key_letter = key_letters[pos_eff];
        if (key_letter == LETTER_J)
        begin
            key_letter = LETTER_I;
        end
        key_code = code_of(square, key_letter);

        // Fold lower case, then J onto I.
        folded = in_item.in_value;
        if (folded >= ASCII_LOWER_A && folded <= ASCII_LOWER_Z)
        begin
            folded = folded - CASE_OFFSET;
        end
        is_letter  = (folded >= ASCII_UPPER_A) && (folded <= ASCII_UPPER_Z);
        letter_idx = LETTER_W'(folded - ASCII_UPPER_A);
        if (letter_idx == LETTER_J)
        begin
            letter_idx = LETTER_I;
        end
        letter_code = code_of(square, letter_idx);
        drop = !is_letter || (letter_code == '0);
    end

    assign accept = push && !q_full;
    assign q_push = accept && ((mode == MODE_DECRYPT) || !drop);

    assign q_entry.mode        = mode;
    assign q_entry.value       = in_item.in_value;
    assign q_entry.key_code    = key_code;
    assign q_entry.letter_code = letter_code;

    always_comb
    begin
        key_pos_next = key_pos_reg;
        if (q_push)
        begin
            key_pos_next = (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);
        end
        else if (accept)
        begin
            key_pos_next = pos_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg <= '0;
        end
        else
        begin
            key_pos_reg <= key_pos_next;
        end
    end

endmodule

[hw/rtl/ncs_fifo.sv]
// Short queue between front and back so each side stalls on its own.
// Depends on ncs_pkg.
module ncs_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  ncs_pkg::work_t wr_entry,
    input  logic           rd,
    output ncs_pkg::work_t rd_entry,
    output logic           q_full,
    output logic           q_empty
);
    import ncs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full   = (count_reg == DEPTH_CNT);
    assign q_empty  = (count_reg == '0);
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign do_wr    = wr && !q_full;
    assign do_rd    = rd && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

[hw/rtl/ncs_back.sv]
// Back end: finishes the cipher arithmetic and holds the result beat in
// an output register. Depends on ncs_pkg.
module ncs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  ncs_pkg::work_t     q_entry,
    output logic               q_pop,
    input  ncs_pkg::square_t   square,
    input  logic               pop,
    output logic               empty,
    output ncs_pkg::out_item_t out_item
);
    import ncs_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;
    logic [7:0]  diff;
    logic [15:0] prod;
    logic [4:0]  row;
    logic [7:0]  row_x10;
    logic [3:0]  col;
    logic [2:0]  row_m1;
    logic [2:0]  col_m1;
    logic [4:0]  cell_idx;
    logic        ok;

    assign q_pop = !q_empty && (!out_valid_reg || pop);

    always_comb
    begin
        diff    = q_entry.value - 8'(q_entry.key_code);
        // Divide by ten through a reciprocal multiply; exact for 8-bit values.
        prod    = 16'(diff) * 16'd205;
        row     = prod[15:11];
        row_x10 = 8'({row, 3'b000}) + 8'({row, 1'b0});
        col     = 4'(diff - row_x10);
        ok      = (q_entry.value >= 8'(q_entry.key_code))
                  && (row >= 5'd1) && (row <= 5'd5)
                  && (col >= 4'd1) && (col <= 4'd5);
        row_m1   = 3'(row - 5'd1);
        col_m1   = 3'(col - 4'd1);
        cell_idx = 5'({row_m1, 2'b00}) + 5'(row_m1) + 5'(col_m1);

        out_next = '0;
        if (q_entry.mode == MODE_ENCRYPT)
        begin
            out_next.out_code = 7'(q_entry.letter_code) + 7'(q_entry.key_code);
        end
        else if (ok)
        begin
            out_next.out_letter = ASCII_UPPER_A + 8'(square[cell_idx]);
        end
        else
        begin
            out_next.bad_input = 1'b1;
        end

        out_valid_next = q_pop || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

endmodule

[hw/rtl/nihilist_cipher_stream.sv]
// Top level of the Nihilist cipher stream: configuration registers and the
// front, queue and back stages. Depends on ncs_pkg, ncs_front, ncs_fifo, ncs_back.
//
// Takes one beat per clock while the queue is not full and gives at most one
// result beat per clock. A beat passes the front lookup in the cycle it is
// pushed and is written to a two-entry queue; the back end then moves it into
// the result register, from which it can be popped. Encrypt bytes that are not
// square letters produce no result and do not advance the key. Write
// configuration only while no result is pending.
module nihilist_cipher_stream #(
    parameter int KEY_MAX = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ncs_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output ncs_pkg::out_item_t out_item,
    input  logic               wr_en,
    input  logic [2:0]         wr_addr,
    input  logic [59:0]        wr_data
);
    import ncs_pkg::*;

    logic        mode_reg;
    logic [59:0] square_part_a_reg;
    logic [59:0] square_part_b_reg;
    logic [4:0]  square_last_reg;
    logic [59:0] key_letters_reg;
    logic [3:0]  key_length_reg;

    square_t square;
    key_t    key_letters;
    work_t   front_entry;
    work_t   back_entry;
    logic    front_push;
    logic    q_full;
    logic    q_empty;
    logic    back_pop;

    assign square      = square_t'({square_last_reg, square_part_b_reg, square_part_a_reg});
    assign key_letters = key_t'(key_letters_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_ENCRYPT;
            square_part_a_reg <= '0;
            square_part_b_reg <= '0;
            square_last_reg   <= '0;
            key_letters_reg   <= '0;
            key_length_reg    <= 4'd1;
        end
        else if (wr_en)
        begin
            case (wr_addr)
                CFG_MODE:          mode_reg          <= wr_data[0];
                CFG_SQUARE_PART_A: square_part_a_reg <= wr_data;
                CFG_SQUARE_PART_B: square_part_b_reg <= wr_data;
                CFG_SQUARE_LAST:   square_last_reg   <= wr_data[4:0];
                CFG_KEY_LETTERS:   key_letters_reg   <= wr_data;
                CFG_KEY_LENGTH:    key_length_reg    <= wr_data[3:0];
                default:           ;
            endcase
        end
    end

    ncs_front #(
        .KEY_MAX (KEY_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .in_item     (in_item),
        .mode        (mode_reg),
        .square      (square),
        .key_letters (key_letters),
        .key_length  (key_length_reg),
        .q_full      (q_full),
        .q_push      (front_push),
        .q_entry     (front_entry)
    );

    ncs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (front_push),
        .wr_entry (front_entry),
        .rd       (back_pop),
        .rd_entry (back_entry),
        .q_full   (q_full),
        .q_empty  (q_empty)
    );

    ncs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (back_entry),
        .q_pop    (back_pop),
        .square   (square),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    assign full = q_full;

endmodule
